// ===== rtl/core/mlp_pkg.sv =====
// Shared types and constants for the perceptron regression block.
package mlp_pkg;

	// Fixed field widths
	localparam int ADDR_W   = 14;
	localparam int WORD_W   = 32;
	localparam int SEL_W    = 3;
	localparam int FEAT_W   = 16;
	localparam int OUT_W    = 22;
	localparam int FEATURES = 6;
	localparam int NONLIN   = 5;

	// Accumulator holds a 256-term sum of floored 65-bit products plus bias
	localparam int ACC_W    = 58;
	// Neuron and term indexes (largest layer is 256 wide)
	localparam int IDX_W    = 8;

	// Output clamp, unsigned Q6.16
	localparam logic [OUT_W-1:0] OUT_MIN = OUT_W'(6554);
	localparam logic [OUT_W-1:0] OUT_MAX = OUT_W'(3276800);

	// Operation of one issued word read
	typedef enum logic [1:0] {
		K_BIAS = 2'd0,
		K_MAC  = 2'd1,
		K_MAC0 = 2'd2,
		K_MEAN = 2'd3
	} kind_t;

	// Source of the multiplier's second operand
	typedef enum logic [1:0] {
		B_FEAT = 2'd0,
		B_BUF  = 2'd1,
		B_DIFF = 2'd2
	} bsrc_t;

	// Destination of a finished neuron
	typedef enum logic [1:0] {
		D_FEAT = 2'd0,
		D_BUF  = 2'd1,
		D_OUT  = 2'd2
	} dst_t;

	// Command from controller to datapath, one per cycle
	typedef struct packed {
		logic             rd;
		logic             zero;
		kind_t            kind;
		bsrc_t            bsrc;
		logic             bbuf;
		logic [IDX_W-1:0] bidx;
		logic             last;
		logic             relu;
		dst_t             dst;
		logic             wbuf;
		logic [IDX_W-1:0] widx;
	} cmd_t;

	// Status back to controller
	typedef struct packed {
		logic out_busy;
	} stat_t;

endpackage

// ===== rtl/core/mlp_regression_inference_top.sv =====
// Timing: a prediction's result becomes valid after the standardization, every layer and
// the output neuron have run, and later still while an earlier result waits in the result register,
// all set by one shared multiply-accumulate fed by the single weight memory read port.
// One prediction is in flight at a time; loads go one per cycle while no prediction runs.
// Reset clears control and the result valid flag; weight memory is undefined until written.
module mlp_regression_inference_top #(
	parameter int MODEL_BANKS  = 4,
	parameter int BANK_WORDS   = 4096,
	parameter int HIDDEN_ONE   = 64,
	parameter int HIDDEN_TWO   = 32,
	parameter int HIDDEN_THREE = 16,
	parameter int HIDDEN_FOUR  = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// weight_address, weight_value, model_select, loop_size, size_matches_vector,
	// tail_remainder, tail_strategy, area_product, size_ratio, zero pad
	input  logic [151:0] s_tdata,
	// command
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// predicted_speedup, zero pad
	output logic [23:0]  m_tdata
);

	localparam int MEM_WORDS = MODEL_BANKS * BANK_WORDS;
	localparam int MEM_AW    = $clog2(MEM_WORDS);
	localparam int D12       = (HIDDEN_ONE > HIDDEN_TWO) ? HIDDEN_ONE : HIDDEN_TWO;
	localparam int D34       = (HIDDEN_THREE + 1 > HIDDEN_FOUR) ? HIDDEN_THREE + 1 : HIDDEN_FOUR;
	localparam int BUF_DEPTH = (D12 > D34) ? D12 : D34;

	logic                              accept;
	mlp_pkg::cmd_t                     cmd;
	mlp_pkg::stat_t                    stat;
	logic [MEM_AW-1:0]                 rd_addr;
	logic [mlp_pkg::OUT_W-1:0]         out_data;

	// Item accepted when both sides agree
	assign accept = s_tvalid && s_tready;

	mlp_ctrl #(
		.MODEL_BANKS (MODEL_BANKS),
		.BANK_WORDS  (BANK_WORDS),
		.HIDDEN_ONE  (HIDDEN_ONE),
		.HIDDEN_TWO  (HIDDEN_TWO),
		.HIDDEN_THREE(HIDDEN_THREE),
		.HIDDEN_FOUR (HIDDEN_FOUR),
		.MEM_AW      (MEM_AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept && s_tuser[0]),
		.model_select(s_tdata[48:46]),
		.ready       (s_tready),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.stat        (stat)
	);

	mlp_datapath #(
		.MEM_WORDS(MEM_WORDS),
		.MEM_AW   (MEM_AW),
		.BUF_DEPTH(BUF_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_we   (accept && !s_tuser[0]),
		.load_addr (s_tdata[13:0]),
		.load_value(s_tdata[45:14]),
		.feat_we   (accept && s_tuser[0]),
		.feat_in   (s_tdata[144:49]),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data)
	);

	assign m_tdata = {2'b00, out_data};

endmodule

// ===== rtl/core/mlp_datapath.sv =====
// Datapath: weight memory, activation buffers, shared multiply-accumulate and result register.
module mlp_datapath #(
	parameter int MEM_WORDS = 16384,
	parameter int MEM_AW    = 14,
	parameter int BUF_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load_we,
	input  logic [mlp_pkg::ADDR_W-1:0]    load_addr,
	input  logic [mlp_pkg::WORD_W-1:0]    load_value,
	input  logic                          feat_we,
	input  logic [mlp_pkg::FEATURES*mlp_pkg::FEAT_W-1:0] feat_in,
	input  mlp_pkg::cmd_t                 cmd,
	input  logic [MEM_AW-1:0]             rd_addr,
	output mlp_pkg::stat_t                stat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mlp_pkg::OUT_W-1:0]     out_data
);

	localparam int BUF_AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

	logic [mlp_pkg::WORD_W-1:0] wmem [MEM_WORDS];
	logic [mlp_pkg::WORD_W-1:0] buf0_mem [BUF_DEPTH];
	logic [mlp_pkg::WORD_W-1:0] buf1_mem [BUF_DEPTH];
	logic signed [mlp_pkg::FEAT_W-1:0] raw_q [mlp_pkg::FEATURES];
	logic signed [mlp_pkg::WORD_W-1:0] feat_q [mlp_pkg::FEATURES];

	logic [mlp_pkg::WORD_W-1:0] mem_rd_s1, buf0_rd_s1, buf1_rd_s1, feat_rd_s1;
	mlp_pkg::cmd_t              ctrl_s1, ctrl_s2, ctrl_s3;
	logic signed [32:0]         d_q;
	logic signed [64:0]         prod_s2;
	logic signed [mlp_pkg::WORD_W-1:0] w_s2;
	logic signed [mlp_pkg::ACC_W-1:0]  acc_q;
	logic                       out_valid_q;
	logic [mlp_pkg::OUT_W-1:0]  out_q;

	logic signed [mlp_pkg::WORD_W-1:0] w_s1, b32_s1, res, act;
	logic signed [32:0]         b_s1, d_next;
	logic signed [mlp_pkg::FEAT_W-1:0] raw_sel;
	logic signed [48:0]         fl_s2;
	logic                       out_wr;

	function automatic logic signed [31:0] sat32(input logic signed [mlp_pkg::ACC_W-1:0] v);
		if (v > mlp_pkg::ACC_W'(64'sd2147483647))
			return 32'sh7fffffff;
		else if (v < -(mlp_pkg::ACC_W'(64'sd2147483648)))
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	// Weight memory: load writes, one registered read port
	always_ff @(posedge clk) begin
		if (load_we && ({18'd0, load_addr} < 32'(MEM_WORDS)))
			wmem[MEM_AW'(load_addr)] <= load_value;
		if (cmd.rd)
			mem_rd_s1 <= wmem[rd_addr];
	end

	// Raw features latched when a prediction starts
	always_ff @(posedge clk) begin
		if (feat_we) begin
			for (int i = 0; i < mlp_pkg::FEATURES; i++)
				raw_q[i] <= feat_in[i*mlp_pkg::FEAT_W +: mlp_pkg::FEAT_W];
		end
	end

	// Stage 1: operand reads
	always_ff @(posedge clk) begin
		buf0_rd_s1 <= buf0_mem[cmd.bidx[BUF_AW-1:0]];
		buf1_rd_s1 <= buf1_mem[cmd.bidx[BUF_AW-1:0]];
		if (cmd.bidx < mlp_pkg::IDX_W'(mlp_pkg::FEATURES))
			feat_rd_s1 <= feat_q[cmd.bidx[2:0]];
		else
			feat_rd_s1 <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else begin
			ctrl_s1 <= cmd;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

	// Operand selection and feature difference
	always_comb begin
		w_s1 = ctrl_s1.zero ? '0 : mem_rd_s1;
		b32_s1 = ctrl_s1.bbuf ? buf1_rd_s1 : buf0_rd_s1;
		case (ctrl_s1.bsrc)
			mlp_pkg::B_FEAT: b_s1 = {feat_rd_s1[31], feat_rd_s1};
			mlp_pkg::B_BUF:  b_s1 = {b32_s1[31], b32_s1};
			mlp_pkg::B_DIFF: b_s1 = d_q;
			default:         b_s1 = '0;
		endcase
		if (ctrl_s1.bidx < mlp_pkg::IDX_W'(mlp_pkg::FEATURES))
			raw_sel = raw_q[ctrl_s1.bidx[2:0]];
		else
			raw_sel = '0;
		d_next = {raw_sel[15], raw_sel, 16'd0} - {w_s1[31], w_s1};
	end

	// Stage 2: multiply
	always_ff @(posedge clk) begin
		if (ctrl_s1.rd && ctrl_s1.kind == mlp_pkg::K_MEAN)
			d_q <= d_next;
		prod_s2 <= b_s1 * w_s1;
		w_s2 <= w_s1;
	end

	// Stage 3: floor and accumulate
	assign fl_s2 = prod_s2[64:16];

	always_ff @(posedge clk) begin
		if (ctrl_s2.rd) begin
			case (ctrl_s2.kind)
				mlp_pkg::K_BIAS: acc_q <= mlp_pkg::ACC_W'(w_s2);
				mlp_pkg::K_MAC:  acc_q <= acc_q + mlp_pkg::ACC_W'(fl_s2);
				mlp_pkg::K_MAC0: acc_q <= mlp_pkg::ACC_W'(fl_s2);
				default:         acc_q <= acc_q;
			endcase
		end
	end

	// Stage 4: saturate, rectify and store
	always_comb begin
		res = sat32(acc_q);
		act = (ctrl_s3.relu && res < 0) ? '0 : res;
		out_wr = ctrl_s3.rd && ctrl_s3.last && ctrl_s3.dst == mlp_pkg::D_OUT;
	end

	always_ff @(posedge clk) begin
		if (ctrl_s3.rd && ctrl_s3.last) begin
			if (ctrl_s3.dst == mlp_pkg::D_FEAT && ctrl_s3.widx < mlp_pkg::IDX_W'(mlp_pkg::FEATURES))
				feat_q[ctrl_s3.widx[2:0]] <= act;
			if (ctrl_s3.dst == mlp_pkg::D_BUF && !ctrl_s3.wbuf)
				buf0_mem[ctrl_s3.widx[BUF_AW-1:0]] <= act;
			if (ctrl_s3.dst == mlp_pkg::D_BUF && ctrl_s3.wbuf)
				buf1_mem[ctrl_s3.widx[BUF_AW-1:0]] <= act;
		end
		if (out_wr) begin
			if (act > $signed({10'd0, mlp_pkg::OUT_MAX}))
				out_q <= mlp_pkg::OUT_MAX;
			else if (act < $signed({10'd0, mlp_pkg::OUT_MIN}))
				out_q <= mlp_pkg::OUT_MIN;
			else
				out_q <= act[mlp_pkg::OUT_W-1:0];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_wr) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_data      = out_q;
	assign stat.out_busy = out_valid_q;

endmodule

// ===== rtl/core/mlp_ctrl.sv =====
// Controller: sequences standardization, layer reads and drains for one prediction.
module mlp_ctrl #(
	parameter int MODEL_BANKS  = 4,
	parameter int BANK_WORDS   = 4096,
	parameter int HIDDEN_ONE   = 64,
	parameter int HIDDEN_TWO   = 32,
	parameter int HIDDEN_THREE = 16,
	parameter int HIDDEN_FOUR  = 8,
	parameter int MEM_AW       = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mlp_pkg::SEL_W-1:0]  model_select,
	output logic                       ready,
	output mlp_pkg::cmd_t              cmd,
	output logic [MEM_AW-1:0]          rd_addr,
	input  mlp_pkg::stat_t             stat
);

	localparam int OFF_W      = 17;
	localparam int OFF_RSCALE = mlp_pkg::FEATURES;
	localparam int OFF_W1     = OFF_RSCALE + mlp_pkg::FEATURES;
	localparam int OFF_B1     = OFF_W1 + HIDDEN_ONE * mlp_pkg::NONLIN;
	localparam int OFF_W2     = OFF_B1 + HIDDEN_ONE;
	localparam int OFF_B2     = OFF_W2 + HIDDEN_TWO * HIDDEN_ONE;
	localparam int OFF_W3     = OFF_B2 + HIDDEN_TWO;
	localparam int OFF_B3     = OFF_W3 + HIDDEN_THREE * HIDDEN_TWO;
	localparam int OFF_LIN    = OFF_B3 + HIDDEN_THREE;
	localparam int OFF_WO1    = OFF_LIN + 1;
	localparam int OFF_BO1    = OFF_WO1 + HIDDEN_FOUR * (HIDDEN_THREE + 1);
	localparam int OFF_WO2    = OFF_BO1 + HIDDEN_FOUR;
	localparam int OFF_BO2    = OFF_WO2 + HIDDEN_FOUR;
	localparam int DRAIN      = 4;

	typedef enum logic [2:0] {
		S_IDLE, S_MEAN, S_SCALE, S_BIAS, S_MAC, S_LIN, S_DRAIN, S_WAITOUT
	} state_t;

	typedef enum logic [2:0] {
		P_STD, P_L1, P_L2, P_L3, P_LIN, P_L4, P_OUT, P_DONE
	} phase_t;

	state_t                    state_q;
	phase_t                    phase_q, phase_nx;
	logic [mlp_pkg::IDX_W-1:0] n_q, j_q;
	logic [OFF_W-1:0]          wptr_q;
	logic [MEM_AW-1:0]         base_q;
	logic [2:0]                drain_q;
	mlp_pkg::cmd_t             cmd_q, cmd_nx;
	logic [MEM_AW-1:0]         addr_q;

	logic [mlp_pkg::IDX_W-1:0] lay_nin_m1, lay_nout_m1;
	logic [OFF_W-1:0]          lay_woff, lay_boff, off;
	mlp_pkg::bsrc_t            lay_bsrc;
	logic                      lay_bbuf, lay_wbuf, lay_relu;
	mlp_pkg::dst_t             lay_dst;
	logic [2:0]                bank;

	// Per-layer shape, offsets and routing
	always_comb begin
		lay_nin_m1  = mlp_pkg::IDX_W'(mlp_pkg::NONLIN - 1);
		lay_nout_m1 = mlp_pkg::IDX_W'(HIDDEN_ONE - 1);
		lay_woff    = OFF_W'(OFF_W1);
		lay_boff    = OFF_W'(OFF_B1);
		lay_bsrc    = mlp_pkg::B_FEAT;
		lay_bbuf    = 1'b0;
		lay_wbuf    = 1'b0;
		lay_relu    = 1'b1;
		lay_dst     = mlp_pkg::D_BUF;
		phase_nx    = P_DONE;
		case (phase_q)
			P_STD: phase_nx = P_L1;
			P_L1:  phase_nx = P_L2;
			P_L2: begin
				lay_nin_m1  = mlp_pkg::IDX_W'(HIDDEN_ONE - 1);
				lay_nout_m1 = mlp_pkg::IDX_W'(HIDDEN_TWO - 1);
				lay_woff    = OFF_W'(OFF_W2);
				lay_boff    = OFF_W'(OFF_B2);
				lay_bsrc    = mlp_pkg::B_BUF;
				lay_wbuf    = 1'b1;
				phase_nx    = P_L3;
			end
			P_L3: begin
				lay_nin_m1  = mlp_pkg::IDX_W'(HIDDEN_TWO - 1);
				lay_nout_m1 = mlp_pkg::IDX_W'(HIDDEN_THREE - 1);
				lay_woff    = OFF_W'(OFF_W3);
				lay_boff    = OFF_W'(OFF_B3);
				lay_bsrc    = mlp_pkg::B_BUF;
				lay_bbuf    = 1'b1;
				phase_nx    = P_LIN;
			end
			P_LIN: phase_nx = P_L4;
			P_L4: begin
				lay_nin_m1  = mlp_pkg::IDX_W'(HIDDEN_THREE);
				lay_nout_m1 = mlp_pkg::IDX_W'(HIDDEN_FOUR - 1);
				lay_woff    = OFF_W'(OFF_WO1);
				lay_boff    = OFF_W'(OFF_BO1);
				lay_bsrc    = mlp_pkg::B_BUF;
				lay_wbuf    = 1'b1;
				phase_nx    = P_OUT;
			end
			P_OUT: begin
				lay_nin_m1  = mlp_pkg::IDX_W'(HIDDEN_FOUR - 1);
				lay_nout_m1 = '0;
				lay_woff    = OFF_W'(OFF_WO2);
				lay_boff    = OFF_W'(OFF_BO2);
				lay_bsrc    = mlp_pkg::B_BUF;
				lay_bbuf    = 1'b1;
				lay_relu    = 1'b0;
				lay_dst     = mlp_pkg::D_OUT;
				phase_nx    = P_DONE;
			end
			default: phase_nx = P_DONE;
		endcase
	end

	// Word offset read in the current state
	always_comb begin
		case (state_q)
			S_MEAN:  off = OFF_W'(n_q);
			S_SCALE: off = OFF_W'(OFF_RSCALE) + OFF_W'(n_q);
			S_BIAS:  off = lay_boff + OFF_W'(n_q);
			S_MAC:   off = wptr_q;
			S_LIN:   off = OFF_W'(OFF_LIN);
			default: off = '0;
		endcase
		bank = (model_select >= 3'd1 && 32'(model_select) <= MODEL_BANKS)
			? model_select - 3'd1 : 3'd0;
	end

	// Command issued for the current state
	always_comb begin
		cmd_nx      = '0;
		cmd_nx.zero = off >= OFF_W'(BANK_WORDS);
		case (state_q)
			S_MEAN: begin
				cmd_nx.rd   = 1'b1;
				cmd_nx.kind = mlp_pkg::K_MEAN;
				cmd_nx.bidx = n_q;
			end
			S_SCALE: begin
				cmd_nx.rd   = 1'b1;
				cmd_nx.kind = mlp_pkg::K_MAC0;
				cmd_nx.bsrc = mlp_pkg::B_DIFF;
				cmd_nx.last = 1'b1;
				cmd_nx.dst  = mlp_pkg::D_FEAT;
				cmd_nx.widx = n_q;
			end
			S_BIAS: begin
				cmd_nx.rd   = 1'b1;
				cmd_nx.kind = mlp_pkg::K_BIAS;
			end
			S_MAC: begin
				cmd_nx.rd   = 1'b1;
				cmd_nx.kind = mlp_pkg::K_MAC;
				cmd_nx.bsrc = lay_bsrc;
				cmd_nx.bbuf = lay_bbuf;
				cmd_nx.bidx = j_q;
				cmd_nx.last = j_q == lay_nin_m1;
				cmd_nx.relu = lay_relu;
				cmd_nx.dst  = lay_dst;
				cmd_nx.wbuf = lay_wbuf;
				cmd_nx.widx = n_q;
			end
			S_LIN: begin
				// linear term of the last feature, appended after layer three
				cmd_nx.rd   = 1'b1;
				cmd_nx.kind = mlp_pkg::K_MAC0;
				cmd_nx.bsrc = mlp_pkg::B_FEAT;
				cmd_nx.bidx = mlp_pkg::IDX_W'(mlp_pkg::FEATURES - 1);
				cmd_nx.last = 1'b1;
				cmd_nx.dst  = mlp_pkg::D_BUF;
				cmd_nx.widx = mlp_pkg::IDX_W'(HIDDEN_THREE);
			end
			default: cmd_nx.rd = 1'b0;
		endcase
	end

	// State and registered commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= P_STD;
			n_q     <= '0;
			j_q     <= '0;
			wptr_q  <= '0;
			base_q  <= '0;
			drain_q <= '0;
			cmd_q   <= '0;
			addr_q  <= '0;
		end else begin
			cmd_q  <= cmd_nx;
			addr_q <= MEM_AW'(32'(base_q) + 32'(off));
			case (state_q)
				S_IDLE: begin
					if (start) begin
						base_q  <= MEM_AW'(32'(bank) * BANK_WORDS);
						phase_q <= P_STD;
						n_q     <= '0;
						state_q <= S_MEAN;
					end
				end
				S_MEAN: begin
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					if (n_q == mlp_pkg::IDX_W'(mlp_pkg::FEATURES - 1)) begin
						phase_q <= phase_nx;
						drain_q <= '0;
						state_q <= S_DRAIN;
					end else begin
						n_q     <= n_q + 1'b1;
						state_q <= S_MEAN;
					end
				end
				S_BIAS: begin
					j_q     <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					wptr_q <= wptr_q + 1'b1;
					j_q    <= j_q + 1'b1;
					if (j_q == lay_nin_m1) begin
						if (n_q == lay_nout_m1) begin
							phase_q <= phase_nx;
							drain_q <= '0;
							state_q <= S_DRAIN;
						end else begin
							n_q     <= n_q + 1'b1;
							state_q <= S_BIAS;
						end
					end
				end
				S_LIN: begin
					phase_q <= phase_nx;
					drain_q <= '0;
					state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 3'(DRAIN - 1)) begin
						n_q    <= '0;
						wptr_q <= lay_woff;
						case (phase_q)
							P_LIN:   state_q <= S_LIN;
							P_OUT:   state_q <= S_WAITOUT;
							P_DONE:  state_q <= S_IDLE;
							default: state_q <= S_BIAS;
						endcase
					end
				end
				S_WAITOUT: begin
					if (!stat.out_busy)
						state_q <= S_BIAS;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign ready   = state_q == S_IDLE;
	assign cmd     = cmd_q;
	assign rd_addr = addr_q;

`ifndef ASSERT_OFF
	a_no_issue_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_q.rd |-> !ready) else $error("word read issued while taking items");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_q.rd && cmd_q.last && cmd_q.dst == mlp_pkg::D_OUT |-> !stat.out_busy)
		else $error("output neuron issued while result register is full");
	a_mean_then_scale: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_q.rd && cmd_q.kind == mlp_pkg::K_MEAN |=>
		cmd_q.rd && cmd_q.bsrc == mlp_pkg::B_DIFF && cmd_q.last)
		else $error("mean read not followed by its scale read");
`endif

endmodule
